// File: rtl/srwt_pkg.sv
// shared types and constants for the tolerance sort and dedup block
`default_nettype none

package srwt_pkg;

    localparam int DATA_W = 32;   // signed q16.16 sample width
    localparam int TOL_W  = 31;   // unsigned tolerance width

    // result of the shared subtract and compare unit
    typedef struct packed {
        logic less;     // minuend below subtrahend
        logic ge_tol;   // minuend - subtrahend at least the tolerance
    } t_cmp;

endpackage

`default_nettype wire

// File: rtl/srwt_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module srwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/srwt_diff_unit.sv
// shared 33-bit subtractor with order and tolerance compare
`default_nettype none

module srwt_diff_unit (
    input  wire logic signed [srwt_pkg::DATA_W-1:0] i_minuend,
    input  wire logic signed [srwt_pkg::DATA_W-1:0] i_subtrahend,
    input  wire logic        [srwt_pkg::TOL_W-1:0]  i_tol,
    output      srwt_pkg::t_cmp                     o_cmp
);

    import srwt_pkg::*;

    logic [DATA_W:0] w_diff;

    // exact difference, one guard bit so it never wraps
    assign w_diff = {i_minuend[DATA_W-1], i_minuend}
                  - {i_subtrahend[DATA_W-1], i_subtrahend};

    assign o_cmp.less   = w_diff[DATA_W];
    assign o_cmp.ge_tol = !w_diff[DATA_W]
                       && (w_diff[DATA_W-1:0] >= {1'b0, i_tol});

endmodule

`default_nettype wire

// File: rtl/sort_remove_within_tolerance.sv
// top level: collect a set, sort it, stream out values that clear the tolerance
//
// Values arrive on s_axis one item per cycle while the block is collecting; the
// item with tlast closes the set. Up to MAX_ITEMS values are kept in a ram;
// further values are dropped and every result of that set carries tuser = 1.
// After the closing item s_axis_tready stays low while the set is sorted in
// place by bubble passes and emitted: each pass streams the ram once through a
// single signed compare unit, reading one entry and writing one entry per
// cycle, so a set of n values takes (n-1) passes to sort (none for n = 1). The
// survivors then stream out in ascending order, one value checked per cycle
// unless m_axis back-pressure stalls, through the same unit, which now checks
// next - current >= tolerance on a 33-bit difference. A value survives if it
// is the largest of the set or its successor exceeds it by at least the
// tolerance, so of a run of close values the largest is kept. tlast marks the
// largest value. The block takes new input again the cycle after the last
// result is loaded into the output register. The user must write the tolerance
// on the cfg channel (always ready) only between sets; the block leaves this unenforced.
`default_nettype none

module sort_remove_within_tolerance #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write channel
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [srwt_pkg::TOL_W-1:0]    i_cfg_data,   // [30:0] tolerance
    // input stream
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    input  wire logic [srwt_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] sample
    input  wire logic                          s_axis_tlast,  // final_item
    // result stream
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output      logic [srwt_pkg::DATA_W-1:0]   m_axis_tdata,  // [31:0] kept_value
    output      logic                          m_axis_tlast,  // run_end
    output      logic [0:0]                    m_axis_tuser   // [0] overflowed
);

    import srwt_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);       // ram address width
    localparam int CW = $clog2(MAX_ITEMS + 1);   // fill count width

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_FIRST,
        ST_SORT_PRIME,
        ST_SORT_STEP,
        ST_SORT_TAIL,
        ST_EMIT_FIRST,
        ST_EMIT_PRIME,
        ST_EMIT_CMP,
        ST_EMIT_LAST
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;       // values stored in this set
    logic                r_ovf, n_ovf;         // a value was dropped
    logic [CW-1:0]       r_pass, n_pass;       // bubble passes done
    logic [AW-1:0]       r_idx, n_idx;         // address of the data now on the ram output
    logic [DATA_W-1:0]   r_carry, n_carry;     // largest value seen in this pass
    logic [DATA_W-1:0]   r_prev, n_prev;       // candidate awaiting its successor
    logic [TOL_W-1:0]    r_tol;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_last, n_out_last;
    logic                r_out_user, n_out_user;

    // ram and unit hookup
    logic                w_we, w_re;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [DATA_W-1:0]   w_wdata, w_rdata;
    logic [DATA_W-1:0]   w_sub;
    t_cmp                w_cmp;

    logic                w_full;
    logic [CW-1:0]       w_fill_close;
    logic [AW-1:0]       w_last_idx;
    logic                w_out_free;
    logic                w_is_sort;

    srwt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sorting compares against the pass carry, emission against the candidate
    assign w_is_sort = (r_state == ST_SORT_PRIME) || (r_state == ST_SORT_STEP);
    assign w_sub     = w_is_sort ? r_carry : r_prev;

    srwt_diff_unit u_diff (
        .i_minuend    (w_rdata),
        .i_subtrahend (w_sub),
        .i_tol        (r_tol),
        .o_cmp        (w_cmp)
    );

    assign w_full       = (r_fill >= CW'(MAX_ITEMS));
    assign w_fill_close = w_full ? r_fill : r_fill + CW'(1);
    assign w_last_idx   = AW'(r_fill - CW'(1));
    assign w_out_free   = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_pass      = r_pass;
        n_idx       = r_idx;
        n_carry     = r_carry;
        n_prev      = r_prev;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;
        w_we        = 1'b0;
        w_waddr     = r_fill[AW-1:0];
        w_wdata     = s_axis_tdata;
        w_re        = 1'b0;
        w_raddr     = r_idx + AW'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (!w_full) begin
                        w_we   = 1'b1;
                        n_fill = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_pass  = '0;
                        n_state = (w_fill_close >= CW'(2)) ? ST_SORT_FIRST : ST_EMIT_FIRST;
                    end
                end
            end
            ST_SORT_FIRST: begin
                w_re    = 1'b1;
                w_raddr = '0;
                n_idx   = '0;
                n_state = ST_SORT_PRIME;
            end
            ST_SORT_PRIME: begin
                n_carry = w_rdata;
                w_re    = 1'b1;
                n_idx   = r_idx + AW'(1);
                n_state = ST_SORT_STEP;
            end
            ST_SORT_STEP: begin
                // smaller one settles one slot back, larger one moves on
                w_we    = 1'b1;
                w_waddr = r_idx - AW'(1);
                w_wdata = w_cmp.less ? w_rdata : r_carry;
                n_carry = w_cmp.less ? r_carry : w_rdata;
                if (r_idx == w_last_idx) begin
                    n_state = ST_SORT_TAIL;
                end else begin
                    w_re  = 1'b1;
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_SORT_TAIL: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_carry;
                n_pass  = r_pass + CW'(1);
                n_state = (n_pass == r_fill - CW'(1)) ? ST_EMIT_FIRST : ST_SORT_FIRST;
            end
            ST_EMIT_FIRST: begin
                w_re    = 1'b1;
                w_raddr = '0;
                n_idx   = '0;
                n_state = ST_EMIT_PRIME;
            end
            ST_EMIT_PRIME: begin
                n_prev = w_rdata;
                if (r_fill == CW'(1)) begin
                    n_state = ST_EMIT_LAST;
                end else begin
                    w_re    = 1'b1;
                    n_idx   = r_idx + AW'(1);
                    n_state = ST_EMIT_CMP;
                end
            end
            ST_EMIT_CMP: begin
                // ram output holds while the result register is busy
                if (!w_cmp.ge_tol || w_out_free) begin
                    if (w_cmp.ge_tol) begin
                        n_out_valid = 1'b1;
                        n_out_data  = r_prev;
                        n_out_last  = 1'b0;
                        n_out_user  = r_ovf;
                    end
                    n_prev = w_rdata;
                    if (r_idx == w_last_idx) begin
                        n_state = ST_EMIT_LAST;
                    end else begin
                        w_re  = 1'b1;
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            ST_EMIT_LAST: begin
                // largest value always survives
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_prev;
                    n_out_last  = 1'b1;
                    n_out_user  = r_ovf;
                    n_fill      = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_tol       <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
        end
        r_pass     <= n_pass;
        r_idx      <= n_idx;
        r_carry    <= n_carry;
        r_prev     <= n_prev;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
    end

    assign o_cfg_ready     = 1'b1;
    assign s_axis_tready   = (r_state == ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tlast    = r_out_last;
    assign m_axis_tuser[0] = r_out_user;

endmodule

`default_nettype wire

// File: rtl/srwt_checker.sv
// port-level checks for the tolerance sort and dedup block, bound to the top level
`default_nettype none

module srwt_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic                        s_axis_tlast,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [srwt_pkg::DATA_W-1:0] m_axis_tdata
);

    // closing item stops intake while the set is sorted and emitted
    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("intake stayed open after closing item");

    // a non-closing item keeps the block collecting
    a_collect_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("intake closed without closing item");

    // results only start while the set is being emitted
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while collecting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind sort_remove_within_tolerance srwt_checker u_srwt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
